[rtl/core/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LimitW   = 9;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SkipW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  // begin error on a skipped byte once more than this many have been counted
  localparam logic [SkipW-1:0] SkipLimit  = 4'd10;
  // instruction and item count bytes at the head of the body
  localparam logic [ByteW-1:0] HeaderBody = 8'd2;

  // reset values of the configuration registers
  localparam logic [ByteW-1:0]  StartByteRst    = 8'h02;
  localparam logic [ByteW-1:0]  EndByteRst      = 8'h03;
  localparam logic              CheckAddressRst = 1'b1;
  localparam logic [ByteW-1:0]  OwnAddressRst   = 8'h01;
  localparam logic [LimitW-1:0] LengthLimitRst  = 9'd256;

  // configuration register indices
  localparam logic [CfgIdxW-1:0] RegStartByte    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEndByte      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCheckAddress = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOwnAddress   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLengthLimit  = 3'd4;

  // frame status codes
  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StBegin   = 3'd1;
  localparam logic [StatusW-1:0] StAddr    = 3'd2;
  localparam logic [StatusW-1:0] StLen     = 3'd3;
  localparam logic [StatusW-1:0] StEnd     = 3'd4;
  localparam logic [StatusW-1:0] StXor     = 3'd5;
  localparam logic [StatusW-1:0] StSum     = 3'd6;
  localparam logic [StatusW-1:0] StTimeout = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0]  start_byte;
    logic [ByteW-1:0]  end_byte;
    logic              check_address;
    logic [ByteW-1:0]  own_address;
    logic [LimitW-1:0] length_limit;
  } fpr_cfg_t;

  typedef struct packed {
    logic                kind;
    logic [ByteW-1:0]    payload_byte;
    logic [ByteW-1:0]    frame_address;
    logic [ByteW-1:0]    frame_instruction;
    logic [ByteW-1:0]    item_count;
    logic [ByteW-1:0]    user_length;
    logic [StatusW-1:0]  status;
  } fpr_res_t;

endpackage

[rtl/core/fpr_frame.sv]
// ----------------------------------------------------------------------------
// fpr_frame
// Frame decoder: per-word state update and result generation.
// ----------------------------------------------------------------------------
module fpr_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [fpr_pkg::ByteW-1:0]   byte_in_i,
  input  logic                        timeout_i,
  input  fpr_pkg::fpr_cfg_t           cfg_i,
  output logic                        res_valid_o,
  output fpr_pkg::fpr_res_t           res_o
);
  import fpr_pkg::*;

  localparam int unsigned PhW = 3;
  localparam logic [PhW-1:0] PhHunt = 3'd0;
  localparam logic [PhW-1:0] PhAddr = 3'd1;
  localparam logic [PhW-1:0] PhLen  = 3'd2;
  localparam logic [PhW-1:0] PhBody = 3'd3;
  localparam logic [PhW-1:0] PhXor  = 3'd4;
  localparam logic [PhW-1:0] PhSum  = 3'd5;
  localparam logic [PhW-1:0] PhEnd  = 3'd6;

  logic [PhW-1:0]   phase_q, phase_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [ByteW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] instr_q, instr_d;
  logic [ByteW-1:0] items_q, items_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] gxor_q, gxor_d;
  logic [ByteW-1:0] gsum_q, gsum_d;

  logic             fin;
  logic [StatusW-1:0] fin_st;
  logic [ByteW:0]   idx_inc;
  logic [LimitW:0]  len_plus;

  assign idx_inc  = {1'b0, idx_q} + 9'd1;
  assign len_plus = {2'b00, byte_in_i} + {2'b00, HeaderBody};

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    idx_d   = idx_q;
    len_d   = len_q;
    addr_d  = addr_q;
    instr_d = instr_q;
    items_d = items_q;
    xor_d   = xor_q;
    sum_d   = sum_q;
    gxor_d  = gxor_q;
    gsum_d  = gsum_q;
    fin     = 1'b0;
    fin_st  = StOk;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (timeout_i) begin
      fin    = 1'b1;
      fin_st = StTimeout;
    end else begin
      case (phase_q)
        PhHunt: begin
          if (byte_in_i != cfg_i.start_byte) begin
            if (skip_q > SkipLimit) begin
              fin    = 1'b1;
              fin_st = StBegin;
            end else begin
              skip_d = skip_q + 4'd1;
            end
          end else begin
            skip_d  = '0;
            phase_d = PhAddr;
          end
        end
        PhAddr: begin
          if (cfg_i.check_address && byte_in_i != cfg_i.own_address) begin
            fin    = 1'b1;
            fin_st = StAddr;
          end else begin
            addr_d  = byte_in_i;
            instr_d = '0;
            items_d = '0;
            xor_d   = byte_in_i;
            sum_d   = byte_in_i;
            phase_d = PhLen;
          end
        end
        PhLen: begin
          len_d = byte_in_i;
          xor_d = xor_q ^ byte_in_i;
          sum_d = sum_q + byte_in_i;
          if (byte_in_i < HeaderBody || len_plus > {1'b0, cfg_i.length_limit}) begin
            fin    = 1'b1;
            fin_st = StLen;
          end else begin
            idx_d   = '0;
            phase_d = PhBody;
          end
        end
        PhBody: begin
          xor_d = xor_q ^ byte_in_i;
          sum_d = sum_q + byte_in_i;
          if (idx_q == 8'd0) begin
            instr_d = byte_in_i;
          end else if (idx_q == 8'd1) begin
            items_d = byte_in_i;
          end else begin
            res_valid_o        = 1'b1;
            res_o.payload_byte = byte_in_i;
          end
          // declared length never exceeds a byte, so the index stays in 8 bits
          idx_d = idx_inc[ByteW-1:0];
          if (idx_inc >= {1'b0, len_q}) phase_d = PhXor;
        end
        PhXor: begin
          gxor_d  = byte_in_i;
          phase_d = PhSum;
        end
        PhSum: begin
          gsum_d  = byte_in_i;
          phase_d = PhEnd;
        end
        PhEnd: begin
          fin = 1'b1;
          if (byte_in_i != cfg_i.end_byte)  fin_st = StEnd;
          else if (gxor_q != xor_q)         fin_st = StXor;
          else if (gsum_q != sum_q)         fin_st = StSum;
          else                              fin_st = StOk;
        end
        default: begin
          phase_d = PhHunt;
          skip_d  = '0;
        end
      endcase
    end

    if (fin) begin
      phase_d     = PhHunt;
      skip_d      = '0;
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.kind  = 1'b1;
      res_o.status = fin_st;
      if (fin_st == StOk) begin
        res_o.frame_address     = addr_q;
        res_o.frame_instruction = instr_q;
        res_o.item_count        = items_q;
        res_o.user_length       = len_q - HeaderBody;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      skip_q  <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      instr_q <= '0;
      items_q <= '0;
      xor_q   <= '0;
      sum_q   <= '0;
      gxor_q  <= '0;
      gsum_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      instr_q <= instr_d;
      items_q <= items_d;
      xor_q   <= xor_d;
      sum_q   <= sum_d;
      gxor_q  <= gxor_d;
      gsum_q  <= gsum_d;
    end
  end

endmodule

[rtl/core/framed_packet_receiver.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Decodes start/address/length/body/XOR/sum/end frames from a byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per ready cycle. Each accepted word updates the
// frame decoder in the same cycle and any result (a user data byte, or the
// status word that closes a frame) lands in the output register, visible the
// cycle after acceptance. The input is ready whenever the output register is
// empty or is being emptied in the same cycle, so with the sink always ready the
// block sustains one byte per clock. Configuration registers are written
// through the plain write port; indices beyond the last register are ignored.
module framed_packet_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fpr_pkg::CfgDataW-1:0]  cfg_data_i,
  // received bytes
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // byte_in[7:0]
  input  logic                          s_axis_tuser_i,   // timeout
  // results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // payload_byte[7:0], frame_address[15:8], frame_instruction[23:16],
  // item_count[31:24], user_length[39:32], status[42:40], zero[47:43]
  output logic [47:0]                   m_axis_tdata_o,
  output logic                          m_axis_tuser_o    // kind
);
  import fpr_pkg::*;

  fpr_cfg_t cfg_q;
  logic     accept;
  logic     res_valid;
  fpr_res_t res;
  logic     out_valid_q;
  fpr_res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= StartByteRst;
      cfg_q.end_byte      <= EndByteRst;
      cfg_q.check_address <= CheckAddressRst;
      cfg_q.own_address   <= OwnAddressRst;
      cfg_q.length_limit  <= LengthLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartByte:    cfg_q.start_byte    <= cfg_data_i[ByteW-1:0];
        RegEndByte:      cfg_q.end_byte      <= cfg_data_i[ByteW-1:0];
        RegCheckAddress: cfg_q.check_address <= cfg_data_i[0];
        RegOwnAddress:   cfg_q.own_address   <= cfg_data_i[ByteW-1:0];
        RegLengthLimit:  cfg_q.length_limit  <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  fpr_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .byte_in_i   (s_axis_tdata_i),
    .timeout_i   (s_axis_tuser_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {5'b00000, out_q.status, out_q.user_length, out_q.item_count,
                            out_q.frame_instruction, out_q.frame_address,
                            out_q.payload_byte};

endmodule
